/* hw/rtl/sdtw_pkg.sv */
// ----------------------------------------------------------------------------
// sdtw_pkg
// Types, constants and the power-of-ten table shared by the signed decimal
// tile writer modules.
// ----------------------------------------------------------------------------
package sdtw_pkg;

  // Input item: where to print, what to print and with which palette.
  typedef struct packed {
    logic [7:0]         start_column;
    logic [4:0]         row_index;
    logic signed [31:0] number_value;
    logic [3:0]         palette_index;
  } sdtw_in_t;

  // Result item: one VRAM write.
  typedef struct packed {
    logic [15:0] vram_address;
    logic [15:0] tile_word;
    logic        last_write;
  } sdtw_out_t;

  // Result of the shared compare-subtract unit.
  typedef struct packed {
    logic        ge;
    logic [31:0] diff;
  } sdtw_csub_t;

  // Register indexes of the configuration port.
  typedef enum logic {
    REG_FIX_BASE = 1'b0
  } sdtw_reg_e;

  localparam logic [15:0] FIX_BASE_RESET = 16'd28672;
  localparam logic [7:0]  ASCII_MINUS    = 8'h2D;
  localparam logic [7:0]  ASCII_ZERO     = 8'h30;
  localparam logic [3:0]  POW_LAST       = 4'd9;

  // Powers of ten from 10^9 (index 0) down to 1 (index 9).
  function automatic logic [31:0] pow_ten(input logic [3:0] idx);
    logic [31:0] p;
    unique case (idx)
      4'd0:    p = 32'd1000000000;
      4'd1:    p = 32'd100000000;
      4'd2:    p = 32'd10000000;
      4'd3:    p = 32'd1000000;
      4'd4:    p = 32'd100000;
      4'd5:    p = 32'd10000;
      4'd6:    p = 32'd1000;
      4'd7:    p = 32'd100;
      4'd8:    p = 32'd10;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

/* hw/rtl/sdtw_csub.sv */
// ----------------------------------------------------------------------------
// sdtw_csub
// Shared compare-subtract unit: compares the remainder with the selected
// power of ten and gives the difference.
// ----------------------------------------------------------------------------
module sdtw_csub (
  input  logic [31:0]         rem_i,
  input  logic [3:0]          pow_idx_i,
  output sdtw_pkg::sdtw_csub_t res_o
);
  import sdtw_pkg::*;

  logic [31:0] pow_val;

  // Table lookup, then one wide compare and subtract.
  assign pow_val    = pow_ten(pow_idx_i);
  assign res_o.ge   = (rem_i >= pow_val);
  assign res_o.diff = rem_i - pow_val;

endmodule

/* hw/rtl/sdtw_ctrl.sv */
// ----------------------------------------------------------------------------
// sdtw_ctrl
// Sequencer for the tile writer: takes an item, strips the sign, drives the
// compare-subtract unit one step per cycle and pushes each character into
// the output register.
// ----------------------------------------------------------------------------
module sdtw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [15:0]           fix_base_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sdtw_pkg::sdtw_in_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sdtw_pkg::sdtw_out_t   out_data_o,
  output logic [31:0]           rem_o,
  output logic [3:0]            pow_idx_o,
  input  sdtw_pkg::sdtw_csub_t  csub_res_i
);
  import sdtw_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIGIT,
    ST_PUSH
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] rem_q, rem_d;
  logic [3:0]  pow_q, pow_d;
  logic [3:0]  digit_q, digit_d;
  logic        started_q, started_d;
  logic        sign_q, sign_d;
  logic [7:0]  col_q, col_d;
  logic [4:0]  row_q, row_d;
  logic [3:0]  pal_q, pal_d;
  logic [7:0]  char_q, char_d;
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  sdtw_out_t   out_data_q, out_data_d;
  logic        out_free;
  logic [15:0] addr;

  assign out_free   = !out_valid_q || out_ready_i;
  assign addr       = fix_base_i + {3'b000, col_q, 5'b00000} + {11'd0, row_q};
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign rem_o       = rem_q;
  assign pow_idx_o   = pow_q;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    pow_d       = pow_q;
    digit_d     = digit_q;
    started_d   = started_q;
    sign_d      = sign_q;
    col_d       = col_q;
    row_d       = row_q;
    pal_d       = pal_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          col_d     = in_data_i.start_column;
          row_d     = in_data_i.row_index;
          pal_d     = in_data_i.palette_index;
          pow_d     = '0;
          digit_d   = '0;
          started_d = 1'b0;
          if (in_data_i.number_value[31]) begin
            // Negative: write the sign first, then print the magnitude.
            rem_d   = 32'd0 - $unsigned(in_data_i.number_value);
            char_d  = ASCII_MINUS;
            last_d  = 1'b0;
            sign_d  = 1'b1;
            state_d = ST_PUSH;
          end else begin
            rem_d   = $unsigned(in_data_i.number_value);
            sign_d  = 1'b0;
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        if (rem_q == 32'd0) begin
          char_d  = ASCII_ZERO;
          last_d  = 1'b1;
          state_d = ST_PUSH;
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (csub_res_i.ge) begin
          rem_d   = csub_res_i.diff;
          digit_d = digit_q + 4'd1;
        end else if (digit_q != 4'd0 || started_q) begin
          char_d    = ASCII_ZERO + {4'b0000, digit_q};
          last_d    = (pow_q == POW_LAST);
          started_d = 1'b1;
          state_d   = ST_PUSH;
        end else begin
          // Leading zero: move on to the next power.
          pow_d = pow_q + 4'd1;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_data_d.vram_address = addr;
          out_data_d.tile_word    = {pal_q, 4'b0000, char_q};
          out_data_d.last_write   = last_q;
          col_d                   = col_q + 8'd1;
          if (last_q) begin
            state_d = ST_IDLE;
          end else if (sign_q) begin
            sign_d  = 1'b0;
            state_d = ST_START;
          end else begin
            pow_d   = pow_q + 4'd1;
            digit_d = '0;
            state_d = ST_DIGIT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rem_q       <= '0;
      pow_q       <= '0;
      digit_q     <= '0;
      started_q   <= 1'b0;
      sign_q      <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      pal_q       <= '0;
      char_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      pow_q       <= pow_d;
      digit_q     <= digit_d;
      started_q   <= started_d;
      sign_q      <= sign_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pal_q       <= pal_d;
      char_q      <= char_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

endmodule

/* hw/rtl/signed_decimal_tile_writer_core.sv */
// ----------------------------------------------------------------------------
// signed_decimal_tile_writer_core
// Prints a signed 32-bit number as decimal tiles into the fix layer.
// ----------------------------------------------------------------------------
// Usage:
// An input item (column, row, signed number, palette) is taken on the
// in_valid_i/in_ready_o handshake while the block is idle. The block then
// produces one VRAM write item per character on out_valid_o/out_ready_i:
// a '-' tile for negative numbers, then the digits without leading zeros;
// the final write of a number carries last_write.
// Each digit is found by repeated compare-subtract of its power of ten in a
// single shared unit, one subtraction per cycle. A new item is taken only
// after the final write of the previous one has been pushed. For a negative
// number the item is accepted in idle, the sequencer enters the push state,
// and the '-' write is loaded into the output register there once it is free.
// A stalled receiver holds the output register and halts the sequencer
// until the write is taken. The fix layer base is set over the APB port at
// byte address 0 and resets to 0x7000. Reset returns the block to idle with
// no write pending.
// ----------------------------------------------------------------------------
module signed_decimal_tile_writer_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sdtw_pkg::sdtw_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sdtw_pkg::sdtw_out_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import sdtw_pkg::*;

  logic [15:0] fix_base_q;
  logic [15:0] fix_base_d;
  logic        reg_hit;
  logic [31:0] rem;
  logic [3:0]  pow_idx;
  sdtw_csub_t  csub_res;

  // Configuration register: written in the APB access phase.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_FIX_BASE);
  assign prdata  = reg_hit ? {16'd0, fix_base_q} : 32'd0;

  always_comb begin
    fix_base_d = fix_base_q;
    if (psel && penable && pwrite && pready && reg_hit) begin
      fix_base_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_base_q <= FIX_BASE_RESET;
    end else begin
      fix_base_q <= fix_base_d;
    end
  end

  // Sequencer and shared compare-subtract unit.
  sdtw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fix_base_i  (fix_base_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .rem_o       (rem),
    .pow_idx_o   (pow_idx),
    .csub_res_i  (csub_res)
  );

  sdtw_csub u_csub (
    .rem_i     (rem),
    .pow_idx_i (pow_idx),
    .res_o     (csub_res)
  );

endmodule
